>>> rtl/alrc_pkg.sv
// ----------------------------------------------------------------------------
// alrc_pkg
// Shared widths, character codes, operator and status codes, command and
// status structs of the left-to-right calculator.
// ----------------------------------------------------------------------------
package alrc_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int CNT_WIDTH   = $clog2(VALUE_WIDTH);
	localparam int RES_WIDTH   = 32;

	localparam logic [7:0] CH_STAR  = 8'd42;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_SLASH = 8'd47;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;
	localparam logic [3:0] DIGIT_BASE = 4'd10;

	localparam logic [2:0] OP_NONE = 3'd0;
	localparam logic [2:0] OP_ADD  = 3'd1;
	localparam logic [2:0] OP_SUB  = 3'd2;
	localparam logic [2:0] OP_MUL  = 3'd3;
	localparam logic [2:0] OP_DIV  = 3'd4;

	localparam logic [1:0] ST_OK  = 2'd0;
	localparam logic [1:0] ST_BAD = 2'd1;
	localparam logic [1:0] ST_DZ  = 2'd2;

	localparam logic [1:0] CC_DIGIT = 2'd0;
	localparam logic [1:0] CC_OPER  = 2'd1;
	localparam logic [1:0] CC_BAD   = 2'd2;

	typedef logic [VALUE_WIDTH-1:0] value_t;

	typedef struct packed {
		logic       digit;
		logic       mark_bad;
		logic       apply;
		logic       set_op;
		logic [2:0] op;
		logic       div_start;
		logic       div_step;
		logic       div_finish;
		logic       emit;
	} cmd_t;

	typedef struct packed {
		logic cur_zero;
		logic pend_div;
		logic div_last;
	} sts_t;

	function automatic logic [1:0] char_class(input logic [7:0] c);
		logic [1:0] cc;
		if (c >= CH_ZERO && c <= CH_NINE)
			cc = CC_DIGIT;
		else if (c == CH_PLUS || c == CH_MINUS || c == CH_STAR || c == CH_SLASH)
			cc = CC_OPER;
		else
			cc = CC_BAD;
		return cc;
	endfunction

	function automatic logic [2:0] char_op(input logic [7:0] c);
		logic [2:0] op;
		unique case (c)
			CH_PLUS:  op = OP_ADD;
			CH_MINUS: op = OP_SUB;
			CH_STAR:  op = OP_MUL;
			default:  op = OP_DIV;
		endcase
		return op;
	endfunction

	function automatic logic [RES_WIDTH-1:0] to_result(input value_t v);
		logic signed [63:0] ext;
		ext = 64'(signed'(v));
		return ext[RES_WIDTH-1:0];
	endfunction

endpackage

>>> rtl/alrc_in_if.sv
// ----------------------------------------------------------------------------
// alrc_in_if
// Character request channel: one ASCII code or an end-of-line mark.
// ----------------------------------------------------------------------------
interface alrc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_code;
	logic       end_of_line;

	modport source (output valid, output char_code, output end_of_line, input ready);
	modport sink   (input valid, input char_code, input end_of_line, output ready);
endinterface

>>> rtl/alrc_out_if.sv
// ----------------------------------------------------------------------------
// alrc_out_if
// Result request channel: line value and status.
// ----------------------------------------------------------------------------
interface alrc_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] result;
	logic [1:0]         status;

	modport source (output valid, output result, output status, input ready);
	modport sink   (input valid, input result, input status, output ready);
endinterface

>>> rtl/alrc_dp.sv
// ----------------------------------------------------------------------------
// alrc_dp
// Datapath: accumulator, current number, pending operator, error flags,
// radix-2 restoring divider and the result register.
// ----------------------------------------------------------------------------
module alrc_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [7:0]          char_code,
	input  alrc_pkg::cmd_t      cmd,
	output alrc_pkg::sts_t      sts,
	output logic signed [31:0]  result,
	output logic [1:0]          status
);

	localparam int VW = alrc_pkg::VALUE_WIDTH;
	localparam int CW = alrc_pkg::CNT_WIDTH;

	alrc_pkg::value_t acc_q;
	alrc_pkg::value_t cur_q;
	logic [2:0]       pend_q;
	logic             bad_q;
	logic             dz_q;

	alrc_pkg::value_t dsr_q;
	alrc_pkg::value_t rem_q;
	alrc_pkg::value_t dvd_q;
	logic             neg_q;
	logic [CW-1:0]    cnt_q;

	logic [31:0]      res_q;
	logic [1:0]       stat_q;

	alrc_pkg::value_t apply_val;
	alrc_pkg::value_t digit_val;
	alrc_pkg::value_t acc_mag;
	alrc_pkg::value_t cur_mag;
	logic [VW:0]      part_rem;
	logic [VW:0]      trial;
	logic [3:0]       digit;

	assign digit     = 4'(char_code - alrc_pkg::CH_ZERO);
	assign digit_val = (cur_q << 3) + (cur_q << 1) + VW'(digit);
	assign acc_mag   = acc_q[VW-1] ? (~acc_q + VW'(1)) : acc_q;
	assign cur_mag   = cur_q[VW-1] ? (~cur_q + VW'(1)) : cur_q;
	assign part_rem  = {rem_q, dvd_q[VW-1]};
	assign trial     = part_rem - {1'b0, dsr_q};

	always_comb begin
		case (pend_q)
			alrc_pkg::OP_ADD: apply_val = acc_q + cur_q;
			alrc_pkg::OP_SUB: apply_val = acc_q - cur_q;
			alrc_pkg::OP_MUL: apply_val = VW'(acc_q * cur_q);
			alrc_pkg::OP_DIV: apply_val = '0;
			default:          apply_val = cur_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q  <= '0;
			cur_q  <= '0;
			pend_q <= alrc_pkg::OP_NONE;
			bad_q  <= 1'b0;
			dz_q   <= 1'b0;
		end else begin
			if (cmd.digit)
				cur_q <= digit_val;
			if (cmd.mark_bad)
				bad_q <= 1'b1;
			if (cmd.apply) begin
				acc_q <= apply_val;
				cur_q <= '0;
				if (pend_q == alrc_pkg::OP_DIV && cur_q == '0)
					dz_q <= 1'b1;
			end
			if (cmd.div_finish) begin
				acc_q <= neg_q ? (~dvd_q + VW'(1)) : dvd_q;
				cur_q <= '0;
			end
			if (cmd.set_op)
				pend_q <= cmd.op;
			if (cmd.emit) begin
				acc_q  <= '0;
				cur_q  <= '0;
				pend_q <= alrc_pkg::OP_NONE;
				bad_q  <= 1'b0;
				dz_q   <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.div_start) begin
			cnt_q <= '0;
		end else if (cmd.div_step) begin
			cnt_q <= cnt_q + CW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.div_start) begin
			dsr_q <= cur_mag;
			dvd_q <= acc_mag;
			rem_q <= '0;
			neg_q <= acc_q[VW-1] ^ cur_q[VW-1];
		end else if (cmd.div_step) begin
			if (!trial[VW]) begin
				rem_q <= trial[VW-1:0];
				dvd_q <= {dvd_q[VW-2:0], 1'b1};
			end else begin
				rem_q <= part_rem[VW-1:0];
				dvd_q <= {dvd_q[VW-2:0], 1'b0};
			end
		end
		if (cmd.emit) begin
			if (bad_q) begin
				res_q  <= '0;
				stat_q <= alrc_pkg::ST_BAD;
			end else if (dz_q) begin
				res_q  <= '0;
				stat_q <= alrc_pkg::ST_DZ;
			end else begin
				res_q  <= alrc_pkg::to_result(acc_q);
				stat_q <= alrc_pkg::ST_OK;
			end
		end
	end

	assign sts.cur_zero = (cur_q == '0);
	assign sts.pend_div = (pend_q == alrc_pkg::OP_DIV);
	assign sts.div_last = (cnt_q == CW'(VW - 1));

	assign result = signed'(res_q);
	assign status = stat_q;

endmodule

>>> rtl/alrc_ctrl.sv
// ----------------------------------------------------------------------------
// alrc_ctrl
// Controller: decodes each character request, sequences the divider and
// hands finished lines to the result register.
// ----------------------------------------------------------------------------
module alrc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic [7:0]     char_code,
	input  logic           end_of_line,
	output logic           in_ready,
	input  logic           out_ready,
	output logic           out_valid,
	input  alrc_pkg::sts_t sts,
	output alrc_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_DIV  = 2'd1;
	localparam logic [1:0] S_FIN  = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;
	logic [2:0] op_q;
	logic       eol_q;
	logic       out_valid_q;
	logic       accept;
	logic       do_div;
	logic       out_free;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign do_div    = sts.pend_div && !sts.cur_zero;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					if (end_of_line) begin
						if (do_div) begin
							cmd.div_start = 1'b1;
							state_d       = S_DIV;
						end else begin
							cmd.apply = 1'b1;
							state_d   = S_EMIT;
						end
					end else begin
						unique case (alrc_pkg::char_class(char_code))
							alrc_pkg::CC_DIGIT: cmd.digit = 1'b1;
							alrc_pkg::CC_OPER: begin
								if (do_div) begin
									cmd.div_start = 1'b1;
									state_d       = S_DIV;
								end else begin
									cmd.apply  = 1'b1;
									cmd.set_op = 1'b1;
									cmd.op     = alrc_pkg::char_op(char_code);
								end
							end
							default: cmd.mark_bad = 1'b1;
						endcase
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_last)
					state_d = S_FIN;
			end
			S_FIN: begin
				cmd.div_finish = 1'b1;
				if (eol_q) begin
					state_d = S_EMIT;
				end else begin
					cmd.set_op = 1'b1;
					cmd.op     = op_q;
					state_d    = S_IDLE;
				end
			end
			default: begin
				if (out_free) begin
					cmd.emit = 1'b1;
					state_d  = S_IDLE;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
			op_q        <= alrc_pkg::OP_NONE;
			eol_q       <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.emit)
				out_valid_q <= 1'b1;
			else if (out_ready)
				out_valid_q <= 1'b0;
			if (accept) begin
				op_q  <= alrc_pkg::char_op(char_code);
				eol_q <= end_of_line;
			end
		end
	end

endmodule

>>> rtl/ascii_left_to_right_calculator_top.sv
// ----------------------------------------------------------------------------
// ascii_left_to_right_calculator_top
// Left-to-right infix calculator fed one ASCII character per request.
//
// in_ch carries char_code and end_of_line; out_ch carries result and status,
// one request per end-of-line. A digit or bad character is done on acceptance.
// An operator or end-of-line applies the pending operator: on acceptance for
// none, +, - and *, and through the S_DIV and S_FIN states for a division
// with a nonzero divisor, run by the one-bit-per-cycle restoring divider.
// An end-of-line then passes through S_EMIT to load the result register;
// in_ch.ready is low while an item is at work.
// The result register parts the two sides: characters keep flowing while a
// result waits; a second end-of-line waits until out_ch.ready takes the
// first. Reset clears the accumulator, the current number, the pending
// operator and both error flags, and drops out_ch.valid.
// ----------------------------------------------------------------------------
module ascii_left_to_right_calculator_top (
	input logic         clk,
	input logic         arst_n,
	alrc_in_if.sink     in_ch,
	alrc_out_if.source  out_ch
);

	alrc_pkg::cmd_t cmd;
	alrc_pkg::sts_t sts;

	alrc_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_ch.valid),
		.char_code   (in_ch.char_code),
		.end_of_line (in_ch.end_of_line),
		.in_ready    (in_ch.ready),
		.out_ready   (out_ch.ready),
		.out_valid   (out_ch.valid),
		.sts         (sts),
		.cmd         (cmd)
	);

	alrc_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.char_code (in_ch.char_code),
		.cmd       (cmd),
		.sts       (sts),
		.result    (out_ch.result),
		.status    (out_ch.status)
	);

	a_no_accept_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_step |-> !in_ch.ready)
		else $error("request accepted during division");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!out_ch.valid || out_ch.ready))
		else $error("pending result overwritten");

	a_error_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_ch.valid && out_ch.status != alrc_pkg::ST_OK) |-> (out_ch.result == 0))
		else $error("nonzero result with error status");

	a_one_update: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0({cmd.apply, cmd.div_start, cmd.div_finish, cmd.digit}))
		else $error("conflicting datapath commands");

	a_div_finish: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.div_step && sts.div_last) |=> cmd.div_finish)
		else $error("division not finished after last step");

endmodule

>>> verif/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ascii_left_to_right_calculator_top. A queue of
// character requests feeds the input channel; each accepted request runs
// through a left-to-right evaluator kept in the bench, and every end of line
// queues the expected value and status. Result requests are checked in order
// while both channels idle at random in two patterns, then never.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import alrc_pkg::*;

	localparam int WATCHDOG_LIMIT = 2000;
	localparam int DRAIN_CYCLES   = 40;
	localparam int PHASE_ITEMS    = 200;

	typedef struct packed {
		logic [7:0] code;
		logic       eol;
	} char_req_t;

	typedef struct packed {
		logic signed [31:0] result;
		logic [1:0]         status;
	} line_result_t;

	logic clk;
	logic arst_n;

	alrc_in_if  in_ch ();
	alrc_out_if out_ch ();

	ascii_left_to_right_calculator_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	char_req_t    char_reqs_q[$];
	line_result_t line_results_q[$];
	char_req_t    next_req;

	value_t     calc_acc;
	value_t     calc_num;
	logic [2:0] calc_op;
	logic       calc_bad;
	logic       calc_dz;

	int send_idle_pct;
	int recv_idle_pct;
	int error_count;
	int chars_taken;
	int lines_ok;
	int lines_bad;
	int lines_dz;

	logic [7:0] op_chars [4] = '{CH_PLUS, CH_MINUS, CH_STAR, CH_SLASH};

	initial clk = 1'b0;
	always #5 clk = ~clk;

	function automatic value_t signed_quotient(input value_t a, input value_t b);
		value_t ma;
		value_t mb;
		value_t q;
		ma = a[VALUE_WIDTH-1] ? -a : a;
		mb = b[VALUE_WIDTH-1] ? -b : b;
		q  = ma / mb;
		if (a[VALUE_WIDTH-1] != b[VALUE_WIDTH-1])
			q = -q;
		return q;
	endfunction

	task automatic apply_operator();
		case (calc_op)
			OP_ADD: calc_acc = calc_acc + calc_num;
			OP_SUB: calc_acc = calc_acc - calc_num;
			OP_MUL: calc_acc = calc_acc * calc_num;
			OP_DIV: begin
				if (calc_num == '0) begin
					calc_dz  = 1'b1;
					calc_acc = '0;
				end else begin
					calc_acc = signed_quotient(calc_acc, calc_num);
				end
			end
			default: calc_acc = calc_num;
		endcase
		calc_num = '0;
	endtask

	task automatic clear_calc();
		calc_acc = '0;
		calc_num = '0;
		calc_op  = OP_NONE;
		calc_bad = 1'b0;
		calc_dz  = 1'b0;
	endtask

	task automatic take_char(input char_req_t req);
		line_result_t lr;
		if (req.eol) begin
			apply_operator();
			if (calc_bad) begin
				lr.status = ST_BAD;
				lr.result = '0;
			end else if (calc_dz) begin
				lr.status = ST_DZ;
				lr.result = '0;
			end else begin
				lr.status = ST_OK;
				lr.result = 32'(signed'(calc_acc));
			end
			line_results_q.push_back(lr);
			clear_calc();
		end else if (req.code >= CH_ZERO && req.code <= CH_NINE) begin
			calc_num = calc_num * value_t'(DIGIT_BASE) + value_t'(req.code - CH_ZERO);
		end else begin
			case (req.code)
				CH_PLUS:  begin apply_operator(); calc_op = OP_ADD; end
				CH_MINUS: begin apply_operator(); calc_op = OP_SUB; end
				CH_STAR:  begin apply_operator(); calc_op = OP_MUL; end
				CH_SLASH: begin apply_operator(); calc_op = OP_DIV; end
				default:  calc_bad = 1'b1;
			endcase
		end
	endtask

	task automatic report_mismatch(input string field, input longint exp_v, input longint got_v);
		$display("mismatch on %s at %0t: expected %0d, got %0d", field, $realtime, exp_v, got_v);
		error_count++;
	endtask

	task automatic push_char(input logic [7:0] code);
		char_req_t req;
		req.code = code;
		req.eol  = 1'b0;
		char_reqs_q.push_back(req);
	endtask

	task automatic push_eol();
		char_req_t req;
		req.code = 8'($urandom_range(255));
		req.eol  = 1'b1;
		char_reqs_q.push_back(req);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++)
			push_char(s[i]);
	endtask

	task automatic push_number();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8) begin
			// leave operand empty
		end else if (pick < 45) begin
			push_char(CH_ZERO + 8'($urandom_range(9)));
		end else if (pick < 75) begin
			push_text($sformatf("%0d", $urandom_range(999)));
		end else if (pick < 92) begin
			push_text($sformatf("%0d", $urandom));
		end else begin
			for (int i = 0; i < 11; i++)
				push_char(CH_ZERO + 8'($urandom_range(9)));
		end
	endtask

	task automatic push_random_line();
		int kind;
		int n_ops;
		int bad_at;
		kind   = $urandom_range(99);
		n_ops  = $urandom_range(4);
		bad_at = (kind < 22) ? $urandom_range(n_ops) : -1;
		if (kind < 5) begin
			for (int i = 0; i <= n_ops; i++)
				push_char(8'($urandom_range(255)));
		end else if (kind < 10) begin
			push_text("2147483648");
			push_char(CH_SLASH);
			push_text("4294967295");
		end else begin
			for (int i = 0; i <= n_ops; i++) begin
				push_number();
				if (i == bad_at)
					push_char(8'($urandom_range(255)));
				if (i < n_ops)
					push_char(op_chars[$urandom_range(3)]);
			end
		end
		push_eol();
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_ch.valid       <= 1'b0;
			in_ch.char_code   <= '0;
			in_ch.end_of_line <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				take_char('{code: in_ch.char_code, eol: in_ch.end_of_line});
				chars_taken++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (char_reqs_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					next_req = char_reqs_q.pop_front();
					in_ch.valid       <= 1'b1;
					in_ch.char_code   <= next_req.code;
					in_ch.end_of_line <= next_req.eol;
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				if (line_results_q.size() == 0) begin
					report_mismatch("unexpected result", 0, out_ch.result);
				end else begin
					line_result_t lr;
					lr = line_results_q.pop_front();
					if (out_ch.status !== lr.status)
						report_mismatch("status", lr.status, out_ch.status);
					if (out_ch.result !== lr.result)
						report_mismatch("result", lr.result, out_ch.result);
					case (lr.status)
						ST_OK:   lines_ok++;
						ST_BAD:  lines_bad++;
						default: lines_dz++;
					endcase
				end
			end
			out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	initial begin
		int stall;
		stall = 0;
		@(posedge arst_n);
		while (stall < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				stall = 0;
			else
				stall++;
		end
		$display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
		$display("[ascii_left_to_right_calculator_top] ERROR");
		$finish;
	end

	initial begin
		int phase_start;
		arst_n            = 1'b0;
		in_ch.valid       = 1'b0;
		in_ch.char_code   = '0;
		in_ch.end_of_line = 1'b0;
		out_ch.ready      = 1'b0;
		send_idle_pct     = 20;
		recv_idle_pct     = 66;
		error_count       = 0;
		chars_taken       = 0;
		lines_ok          = 0;
		lines_bad         = 0;
		lines_dz          = 0;
		clear_calc();

		push_eol();
		push_char(CH_MINUS);
		push_char(CH_NINE);
		push_char(CH_PLUS);
		push_eol();
		push_text("6*7/0");
		push_eol();
		push_char(8'hff);
		push_char(CH_SLASH);
		push_char(CH_ZERO);
		push_eol();
		push_char(8'h00);
		push_eol();

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;

		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 20; recv_idle_pct = 66; end
				1: begin send_idle_pct = 66; recv_idle_pct = 20; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			phase_start = char_reqs_q.size();
			while (char_reqs_q.size() - phase_start < PHASE_ITEMS)
				push_random_line();
			while (char_reqs_q.size() != 0)
				@(posedge clk);
		end

		while (in_ch.valid || line_results_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (line_results_q.size() != 0)
			report_mismatch("results left over", 0, line_results_q.size());

		$display("covered %0d characters and %0d lines: %0d ok, %0d bad character, %0d divide by zero",
			chars_taken, lines_ok + lines_bad + lines_dz, lines_ok, lines_bad, lines_dz);
		$display("idle patterns: sender 20/receiver 66, sender 66/receiver 20, none; %0d mismatches",
			error_count);
		if (error_count == 0)
			$display("[ascii_left_to_right_calculator_top] OK");
		else
			$display("[ascii_left_to_right_calculator_top] ERROR");
		$finish;
	end

endmodule
